>>> design/fifo_ordered_priority_queue_core_macros.svh
// Assertion macros for the ordered priority queue.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FIFO_ORDERED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define FIFO_ORDERED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Checked only while out of reset.
`define FOPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define FOPQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> design/fopq_pkg.sv
// Package for the ordered priority queue: defaults, request and status codes,
// and the per-cell operation code. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fopq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PRIO_WIDTH_DEF = 8;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD_NEW  = 2'd1,
        CELL_TAKE_PREV = 2'd2,
        CELL_TAKE_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> design/fopq_req_if.sv
// Request channel of the ordered priority queue: valid/ready and the request word.
// Depends on fopq_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface fopq_req_if #(
    parameter int DATA_WIDTH = fopq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = fopq_pkg::PRIO_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [DATA_WIDTH-1:0] data_in;
    logic [PRIO_WIDTH-1:0] priority_req;

    modport source (output valid, output req_type, output data_in,
                    output priority_req, input ready);
    modport sink   (input valid, input req_type, input data_in,
                    input priority_req, output ready);
endinterface

`default_nettype wire

>>> design/fopq_rsp_if.sv
// Response channel of the ordered priority queue: valid/ready and the result word.
// Depends on fopq_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface fopq_rsp_if #(
    parameter int DATA_WIDTH = fopq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_WIDTH  = $clog2(fopq_pkg::DEPTH_DEF + 1)
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] data_out;
    logic [1:0]            status;
    logic [CNT_WIDTH-1:0]  occupancy;

    modport source (output valid, output data_out, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input data_out, input status,
                    input occupancy, output ready);
endinterface

`default_nettype wire

>>> design/fifo_ordered_priority_queue_core.sv
// Ordered priority queue: sorted chain of cells, highest priority at the head.
// Depends on fopq_pkg, fopq_req_if, fopq_rsp_if, fopq_cell and the macro header.
//
// Usage:
//   i_req carries one request word per handshake: req_type (enqueue or
//   dequeue), data_in and priority_req. o_rsp returns exactly one word per
//   request: data_out (removed word on a good dequeue, else zero), status
//   (ok, empty on dequeue, full on enqueue) and occupancy after the request.
//   Entries stay sorted by priority, older first among equals, so a dequeue
//   always takes cell 0 and an enqueue slots in by one compare in every cell.
//   Latency: the response is valid the cycle after the request is taken.
//   Throughput: one request per cycle while the receiver takes each response;
//   each cell compares with the incoming priority and loads from itself or a neighbour.
//   An enqueue on a full queue is dropped and reported as full.
//   Reset empties the queue at once; no clearing pass is needed.
//   If the receiver stalls, the response register holds and i_req.ready
//   drops until the held word is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_ordered_priority_queue_core_macros.svh"

module fifo_ordered_priority_queue_core #(
    parameter int DEPTH      = fopq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fopq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = fopq_pkg::PRIO_WIDTH_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    fopq_req_if.sink   i_req,
    fopq_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [DATA_WIDTH-1:0] r_out_data;
    logic [DATA_WIDTH-1:0] n_out_data;
    fopq_pkg::t_status     r_out_status;
    fopq_pkg::t_status     n_out_status;
    logic [CNT_W-1:0]      r_out_occ;

    logic accept;
    logic is_deq;
    logic enq_ok;
    logic deq_ok;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic [DEPTH-1:0]      cell_ge_raw;
    logic [DEPTH-1:0]      cell_ge;
    fopq_pkg::t_cell_ctrl  cell_ctrl [DEPTH];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_deq      = (i_req.req_type == fopq_pkg::REQ_DEQ);
    assign enq_ok      = accept && !is_deq && (r_count != CNT_FULL);
    assign deq_ok      = accept && is_deq && (r_count != '0);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] prev_data;
            logic [PRIO_WIDTH-1:0] prev_prio;
            logic [DATA_WIDTH-1:0] next_data;
            logic [PRIO_WIDTH-1:0] next_prio;
            logic                  prev_ge;

            // Cells past the fill level never count as holding a higher entry.
            assign cell_ge[g] = cell_ge_raw[g] && (CNT_W'(g) < r_count);

            if (g == 0) begin : g_head
                assign prev_data = i_req.data_in;
                assign prev_prio = i_req.priority_req;
                assign prev_ge   = 1'b1;
            end else begin : g_body
                assign prev_data = cell_data[g-1];
                assign prev_prio = cell_prio[g-1];
                assign prev_ge   = cell_ge[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign next_data = cell_data[g];
                assign next_prio = cell_prio[g];
            end else begin : g_mid
                assign next_data = cell_data[g+1];
                assign next_prio = cell_prio[g+1];
            end

            always_comb begin
                priority if (enq_ok) begin
                    priority if (cell_ge[g]) begin
                        cell_ctrl[g].op = fopq_pkg::CELL_HOLD;
                    end else if (prev_ge) begin
                        cell_ctrl[g].op = fopq_pkg::CELL_LOAD_NEW;
                    end else begin
                        cell_ctrl[g].op = fopq_pkg::CELL_TAKE_PREV;
                    end
                end else if (deq_ok) begin
                    cell_ctrl[g].op = fopq_pkg::CELL_TAKE_NEXT;
                end else begin
                    cell_ctrl[g].op = fopq_pkg::CELL_HOLD;
                end
            end

            fopq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .PRIO_WIDTH (PRIO_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (cell_ctrl[g]),
                .i_new_data  (i_req.data_in),
                .i_new_prio  (i_req.priority_req),
                .i_prev_data (prev_data),
                .i_prev_prio (prev_prio),
                .i_next_data (next_data),
                .i_next_prio (next_prio),
                .o_data      (cell_data[g]),
                .o_prio      (cell_prio[g]),
                .o_ge        (cell_ge_raw[g])
            );
        end
    endgenerate

    always_comb begin
        n_count      = r_count;
        n_out_data   = '0;
        n_out_status = fopq_pkg::ST_OK;
        priority if (enq_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (deq_ok) begin
            n_count    = r_count - CNT_W'(1);
            n_out_data = cell_data[0];
        end else if (accept && is_deq) begin
            n_out_status = fopq_pkg::ST_EMPTY;
        end else if (accept) begin
            n_out_status = fopq_pkg::ST_FULL;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        priority if (accept) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result word: load on accept, hold while stalled.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_occ    <= n_count;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.data_out  = r_out_data;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.occupancy = r_out_occ;

    `FOPQ_ASSERT(a_count_bound, r_count <= CNT_FULL, "fill count above depth")
    `FOPQ_ASSERT(a_deq_count, deq_ok |=> r_count == $past(r_count) - CNT_W'(1),
        "dequeue did not drop the fill count by one")
    `FOPQ_ASSERT(a_full_occ,
        r_out_valid && (r_out_status == fopq_pkg::ST_FULL) |-> r_out_occ == CNT_FULL,
        "full reported below depth")
    `FOPQ_ASSERT(a_empty_resp,
        r_out_valid && (r_out_status == fopq_pkg::ST_EMPTY)
            |-> (r_out_occ == '0) && (r_out_data == '0),
        "empty response with entries or data")
    `FOPQ_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> (r_count == '0) && !r_out_valid,
        "reset left entries or a pending word")

endmodule

`default_nettype wire

>>> design/fopq_cell.sv
// One storage cell of the sorted chain: a data word and its priority.
// Depends on fopq_pkg for the cell operation code.
`timescale 1ns / 1ps
`default_nettype none

module fopq_cell #(
    parameter int DATA_WIDTH = fopq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = fopq_pkg::PRIO_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  fopq_pkg::t_cell_ctrl    i_ctrl,
    input  wire  [DATA_WIDTH-1:0]   i_new_data,
    input  wire  [PRIO_WIDTH-1:0]   i_new_prio,
    input  wire  [DATA_WIDTH-1:0]   i_prev_data,
    input  wire  [PRIO_WIDTH-1:0]   i_prev_prio,
    input  wire  [DATA_WIDTH-1:0]   i_next_data,
    input  wire  [PRIO_WIDTH-1:0]   i_next_prio,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [PRIO_WIDTH-1:0]   o_prio,
    output logic                    o_ge
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [PRIO_WIDTH-1:0] r_prio;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            fopq_pkg::CELL_HOLD: begin
                r_data <= r_data;
                r_prio <= r_prio;
            end
            fopq_pkg::CELL_LOAD_NEW: begin
                r_data <= i_new_data;
                r_prio <= i_new_prio;
            end
            fopq_pkg::CELL_TAKE_PREV: begin
                r_data <= i_prev_data;
                r_prio <= i_prev_prio;
            end
            fopq_pkg::CELL_TAKE_NEXT: begin
                r_data <= i_next_data;
                r_prio <= i_next_prio;
            end
        endcase
    end

    // Equal priority keeps its place so the newcomer lands behind it.
    assign o_ge   = (r_prio >= i_new_prio);
    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

>>> test/fifo_ordered_priority_queue_checker.sv
// Checker for the ordered priority queue: watches both channels, keeps its own
// copy of the queue and compares every response word. Depends on fopq_pkg and
// the fopq_req_if / fopq_rsp_if interfaces.
`timescale 1ns / 1ps

module fifo_ordered_priority_queue_checker #(
    parameter int DEPTH      = fopq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = fopq_pkg::DATA_WIDTH_DEF,
    parameter int PRIO_WIDTH = fopq_pkg::PRIO_WIDTH_DEF,
    parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    fopq_req_if  i_req,
    fopq_rsp_if  i_rsp,
    output int   o_mismatch_count,
    output int   o_results_due
);
    import fopq_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic [PRIO_WIDTH-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        t_status               status;
        logic [CNT_WIDTH-1:0]  occupancy;
    } t_result;

    t_entry  stored_entries[$];
    t_result results_due[$];
    int      mismatches;

    // Apply one request to the stored entries and return the response it earns.
    function automatic t_result serve_request(input t_req_kind kind,
                                              input logic [DATA_WIDTH-1:0] data,
                                              input logic [PRIO_WIDTH-1:0] prio);
        t_result rsp;
        t_entry  ent;
        int      best;
        rsp.data   = '0;
        rsp.status = ST_OK;
        if (kind == REQ_ENQ) begin
            if (stored_entries.size() >= DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                ent.data = data;
                ent.prio = prio;
                stored_entries.push_back(ent);
            end
        end else if (stored_entries.size() == 0) begin
            rsp.status = ST_EMPTY;
        end else begin
            // strict compare keeps the oldest among equal priorities
            best = 0;
            for (int i = 1; i < stored_entries.size(); i++) begin
                if (stored_entries[i].prio > stored_entries[best].prio) begin
                    best = i;
                end
            end
            rsp.data = stored_entries[best].data;
            stored_entries.delete(best);
        end
        rsp.occupancy = CNT_WIDTH'(stored_entries.size());
        return rsp;
    endfunction

    initial begin
        mismatches       = 0;
        o_mismatch_count = 0;
        o_results_due    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            stored_entries.delete();
            results_due.delete();
        end else begin
            // take the request first so a same-edge response still pops the oldest
            if (i_req.valid && i_req.ready) begin
                results_due.push_back(serve_request(t_req_kind'(i_req.req_type),
                                                    i_req.data_in, i_req.priority_req));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (results_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: unexpected word: data %h status %0d occupancy %0d",
                                 $realtime, i_rsp.data_out, i_rsp.status, i_rsp.occupancy);
                    end
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_rsp.data_out !== want.data || i_rsp.status !== want.status ||
                        i_rsp.occupancy !== want.occupancy) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch: data %h/%h status %0d/%0d occ %0d/%0d",
                                     $realtime, want.data, i_rsp.data_out,
                                     want.status, i_rsp.status,
                                     want.occupancy, i_rsp.occupancy);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_results_due    <= results_due.size();
    end

endmodule

>>> test/fifo_ordered_priority_queue_core_tb.sv
// Testbench top for the ordered priority queue: clock, reset, request and
// response traffic, verdict. Depends on fopq_pkg, both channel interfaces,
// the core and fifo_ordered_priority_queue_checker.
`timescale 1ns / 1ps

module fifo_ordered_priority_queue_core_tb;
    import fopq_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int RANDOM_PER_PASS = 340;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 200000;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   results_due;
    int   cycle_count;
    int   send_idle_pct;
    int   rsp_stall_pct;
    logic hold_off_req;

    fopq_req_if req_if ();
    fopq_rsp_if rsp_if ();

    fifo_ordered_priority_queue_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    fifo_ordered_priority_queue_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req            (req_if),
        .i_rsp            (rsp_if),
        .o_mismatch_count (mismatch_count),
        .o_results_due    (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off once requested.
    initial begin : receiver
        int held_off;
        held_off = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && held_off < HOLD_OFF_CYCLES) begin
                rsp_if.ready <= 1'b0;
                held_off++;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
            end
        end
    end

    // Offer one request word and hold it until taken; idle first at random.
    task automatic send_request(input t_req_kind kind, input logic [31:0] data,
                                input logic [7:0] prio);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.data_in      <= data;
        req_if.priority_req <= prio;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
    endtask

    // Bursts of one kind so the queue swings between empty and full.
    task automatic run_random_traffic(input int n_items);
        int        sent;
        int        burst;
        int        prio_mode;
        t_req_kind burst_kind;
        t_req_kind kind;
        logic [7:0] prio;
        sent = 0;
        while (sent < n_items) begin
            burst_kind = ($urandom_range(1) == 0) ? REQ_ENQ : REQ_DEQ;
            burst      = $urandom_range(1, 20);
            prio_mode  = $urandom_range(3);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                kind = burst_kind;
                if ($urandom_range(7) == 0) begin
                    kind = (kind == REQ_ENQ) ? REQ_DEQ : REQ_ENQ;
                end
                case (prio_mode)
                    0: prio = 8'($urandom_range(3));
                    1: prio = ($urandom_range(1) == 0) ? 8'h00 : 8'hff;
                    default: prio = 8'($urandom_range(255));
                endcase
                send_request(kind, $urandom(), prio);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_ENQ;
        req_if.data_in      <= '0;
        req_if.priority_req <= '0;
        hold_off_req        <= 1'b0;
        send_idle_pct       <= 0;
        rsp_stall_pct       <= 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty dequeue, extremes, ties at both ends, drain past empty.
        send_request(REQ_DEQ, 32'h0000_0000, 8'h00);
        send_request(REQ_ENQ, 32'h0000_0000, 8'h00);
        send_request(REQ_ENQ, 32'hffff_ffff, 8'hff);
        send_request(REQ_ENQ, 32'ha5a5_a5a5, 8'h00);
        send_request(REQ_ENQ, 32'h5a5a_5a5a, 8'hff);
        send_request(REQ_ENQ, 32'h0000_0001, 8'h80);
        repeat (6) send_request(REQ_DEQ, 32'hffff_ffff, 8'hff);

        // Long receiver hold-off while the sender keeps offering requests; also fills the queue.
        hold_off_req <= 1'b1;
        for (int k = 0; k < DEPTH + 4; k++) begin
            send_request(REQ_ENQ, $urandom(), 8'($urandom_range(255)));
        end
        for (int k = 0; k < DEPTH + 4; k++) begin
            send_request(REQ_DEQ, $urandom(), 8'($urandom_range(255)));
        end

        run_random_traffic(RANDOM_PER_PASS);
        send_idle_pct <= 54;
        run_random_traffic(RANDOM_PER_PASS);
        send_idle_pct <= 0;
        rsp_stall_pct <= 54;
        run_random_traffic(RANDOM_PER_PASS);
        send_idle_pct <= 28;
        rsp_stall_pct <= 28;
        run_random_traffic(RANDOM_PER_PASS);

        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (results_due != 0);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
